>>> hdl/rcl_pkg.sv
// ----------------------------------------------------------------------------
// rcl_pkg
// Types and constants shared by the rotator command line parser modules.
// ----------------------------------------------------------------------------
package rcl_pkg;

	localparam int GOAL_W   = 24;
	localparam int CFG_IDX_W = 2;
	localparam int EV_W     = 3;
	localparam int TDATA_W  = 56;
	localparam int NCAP     = 5;

	// number magnitude saturates early: anything past the cap clamps anyway
	localparam int MAG_W    = 19;
	localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1 << 18);
	localparam int FRAC_W   = 7;
	localparam int SCALED_W = 25;
	localparam int VAL_W    = 26;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_UL    = 8'h4C;
	localparam logic [7:0] CH_US    = 8'h53;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	typedef enum logic [EV_W-1:0] {
		EV_STORED  = 3'd0,
		EV_IGNORED = 3'd1,
		EV_QUERY   = 3'd2,
		EV_TARGET  = 3'd3,
		EV_STOP    = 3'd4
	} rcl_event_t;

	localparam logic [CFG_IDX_W-1:0] CFG_AZ_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AZ_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EL_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EL_MAX = 2'd3;

	typedef struct packed {
		logic store;
		logic line_start;
		logic scan_run;
		logic scale;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic eol;
		logic scan_done;
		logic out_free;
	} ctl_sts_t;

endpackage

>>> hdl/rcl_ram.sv
// ----------------------------------------------------------------------------
// rcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hdl/rcl_num.sv
// ----------------------------------------------------------------------------
// rcl_num
// Character-serial decimal reader: hundredths of a degree, letters reject.
// ----------------------------------------------------------------------------
module rcl_num #(
	parameter int NUMBER_CHARS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic                              feed,
	input  logic [7:0]                        ch,
	output logic                              rejected,
	output logic signed [rcl_pkg::VAL_W-1:0]  value
);

	import rcl_pkg::*;

	localparam int K_W   = $clog2(NUMBER_CHARS + 1);
	localparam int ACC_W = MAG_W + 4;

	typedef enum logic [1:0] {NP_WS, NP_INT, NP_FRAC, NP_STOP} np_state_t;

	np_state_t          st_q;
	logic [K_W-1:0]     k_q;
	logic               rej_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [1:0]         fcnt_q;

	logic               step;
	logic               is_digit;
	logic               is_letter;
	logic               is_ws;
	logic [3:0]         d;
	logic [ACC_W-1:0]   acc;
	logic [MAG_W-1:0]   mag_next;
	logic [VAL_W-1:0]   wide;
	logic [SCALED_W-1:0] scaled;

	always_comb begin
		step      = feed && (k_q != K_W'(NUMBER_CHARS));
		is_digit  = (ch >= CH_0) && (ch <= CH_9);
		is_letter = ((ch >= CH_UA) && (ch <= CH_UZ)) || ((ch >= CH_LA) && (ch <= CH_LZ));
		is_ws     = (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
		d         = ch[3:0];
		acc       = (ACC_W'(mag_q) << 3) + (ACC_W'(mag_q) << 1) + ACC_W'(d);
		mag_next  = (acc > ACC_W'(MAG_CAP)) ? MAG_CAP : acc[MAG_W-1:0];
		wide      = (VAL_W'(mag_q) << 6) + (VAL_W'(mag_q) << 5) + (VAL_W'(mag_q) << 2)
			+ VAL_W'(frac_q);
		scaled    = wide[SCALED_W-1:0];
		value     = neg_q ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
		rejected  = rej_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= NP_WS;
			k_q    <= '0;
			rej_q  <= 1'b0;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			frac_q <= '0;
			fcnt_q <= '0;
		end else if (clear) begin
			st_q   <= NP_WS;
			k_q    <= '0;
			rej_q  <= 1'b0;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			frac_q <= '0;
			fcnt_q <= '0;
		end else if (step) begin
			k_q <= k_q + 1'b1;
			if (is_letter) begin
				rej_q <= 1'b1;
			end
			unique case (st_q)
				NP_WS: begin
					if (is_ws) begin
						st_q <= NP_WS;
					end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
						neg_q <= (ch == CH_MINUS);
						st_q  <= NP_INT;
					end else if (is_digit) begin
						mag_q <= mag_next;
						st_q  <= NP_INT;
					end else if (ch == CH_DOT) begin
						st_q <= NP_FRAC;
					end else begin
						st_q <= NP_STOP;
					end
				end
				NP_INT: begin
					if (is_digit) begin
						mag_q <= mag_next;
					end else if (ch == CH_DOT) begin
						st_q <= NP_FRAC;
					end else begin
						st_q <= NP_STOP;
					end
				end
				NP_FRAC: begin
					if (is_digit) begin
						if (fcnt_q == 2'd0) begin
							frac_q <= (FRAC_W'(d) << 3) + (FRAC_W'(d) << 1);
						end else if (fcnt_q == 2'd1) begin
							frac_q <= frac_q + FRAC_W'(d);
						end
						if (fcnt_q != 2'd2) begin
							fcnt_q <= fcnt_q + 1'b1;
						end
					end else begin
						st_q <= NP_STOP;
					end
				end
				NP_STOP: begin
					st_q <= NP_STOP;
				end
				default: begin
					st_q <= NP_STOP;
				end
			endcase
		end
	end

endmodule

>>> hdl/rcl_datapath.sv
// ----------------------------------------------------------------------------
// rcl_datapath
// Line store, scan walker, token tracking, clamping and result register.
// ----------------------------------------------------------------------------
module rcl_datapath #(
	parameter int LINE_MAX     = 64,
	parameter int NUMBER_CHARS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rcl_pkg::ctl_cmd_t                    cmd,
	output rcl_pkg::ctl_sts_t                    sts,
	input  logic [7:0]                           in_byte,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [rcl_pkg::TDATA_W-1:0]          out_data,
	output logic [rcl_pkg::EV_W-1:0]             out_user,
	input  logic                                 cfg_valid,
	input  logic [rcl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rcl_pkg::GOAL_W-1:0]           cfg_data
);

	import rcl_pkg::*;

	localparam int LEN_W = $clog2(LINE_MAX + 1);
	localparam int AW    = $clog2(LINE_MAX);

	typedef enum logic [2:0] {P_TOK0, P_SPACE, P_E, P_TOK1, P_DONE} phase_t;

	logic [LEN_W-1:0]          len_q;
	logic [LEN_W-1:0]          rd_idx_q;
	logic [LEN_W-1:0]          idx_s1;
	logic                      vld_s1;
	logic                      stop_q;
	phase_t                    phase_q;
	logic                      b_found_q;
	logic [7:0]                c_q [NCAP];

	logic signed [GOAL_W-1:0]  az_min_q, az_max_q, el_min_q, el_max_q;
	logic signed [GOAL_W-1:0]  az_goal_q, el_goal_q;
	logic signed [VAL_W-1:0]   val_a_q, val_b_q;
	logic                      out_valid_q;
	logic [TDATA_W-1:0]        out_data_q;
	logic [EV_W-1:0]           out_user_q;

	logic                      wr_en;
	logic                      issue;
	logic [7:0]                ch;
	logic                      live;
	logic                      proc;
	logic                      feed_a, feed_b;
	logic                      rej_a, rej_b;
	logic signed [VAL_W-1:0]   num_a, num_b;

	logic                      is_az, is_query, is_el, is_stop;
	logic                      az_up, el_up;
	rcl_event_t                ev;
	logic signed [GOAL_W-1:0]  a_lo, a_hi, clamp_a, clamp_b;
	logic signed [GOAL_W-1:0]  az_new, el_new;

	function automatic logic signed [GOAL_W-1:0] clamp_goal(
		input logic signed [VAL_W-1:0]  v,
		input logic signed [GOAL_W-1:0] lo,
		input logic signed [GOAL_W-1:0] hi
	);
		logic signed [VAL_W-1:0] r;
		r = v;
		if (r > VAL_W'(hi)) begin
			r = VAL_W'(hi);
		end
		if (r < VAL_W'(lo)) begin
			r = VAL_W'(lo);
		end
		return GOAL_W'(r);
	endfunction

	assign wr_en = cmd.store && (len_q != LEN_W'(LINE_MAX));
	assign issue = cmd.scan_run && !stop_q && (rd_idx_q != len_q);

	rcl_ram #(
		.WIDTH(8),
		.DEPTH(LINE_MAX)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[AW-1:0]),
		.wr_data (in_byte),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (ch)
	);

	always_comb begin
		live   = vld_s1 && !stop_q;
		proc   = live && (ch != 8'h00);
		feed_a = proc && (phase_q == P_TOK0) && (ch != CH_SP) && (idx_s1 >= LEN_W'(2));
		feed_b = proc && (phase_q == P_TOK1) && (ch != CH_SP);
	end

	rcl_num #(.NUMBER_CHARS(NUMBER_CHARS)) u_num_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cmd.line_start),
		.feed     (feed_a),
		.ch       (ch),
		.rejected (rej_a),
		.value    (num_a)
	);

	rcl_num #(.NUMBER_CHARS(NUMBER_CHARS)) u_num_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cmd.line_start),
		.feed     (feed_b),
		.ch       (ch),
		.rejected (rej_b),
		.value    (num_b)
	);

	always_comb begin
		sts.eol       = (in_byte == CH_LF) || (in_byte == CH_CR);
		sts.scan_done = !vld_s1 && (stop_q || (rd_idx_q == len_q));
		sts.out_free  = !out_valid_q || out_ready;
	end

	// line decode at the end of a scan
	always_comb begin
		is_az    = (c_q[0] == CH_UA) && (c_q[1] == CH_UZ);
		is_query = is_az && (c_q[2] == CH_SP) && (c_q[3] == CH_UE) && (c_q[4] == CH_UL);
		is_el    = (c_q[0] == CH_UE) && (c_q[1] == CH_UL);
		is_stop  = (c_q[0] == CH_US) && (c_q[1] == CH_UA) && (c_q[2] == CH_SP)
			&& (c_q[3] == CH_US) && (c_q[4] == CH_UE);
		a_lo     = is_az ? az_min_q : el_min_q;
		a_hi     = is_az ? az_max_q : el_max_q;
		clamp_a  = clamp_goal(val_a_q, a_lo, a_hi);
		clamp_b  = clamp_goal(val_b_q, el_min_q, el_max_q);
		az_up    = 1'b0;
		el_up    = 1'b0;
		az_new   = az_goal_q;
		el_new   = el_goal_q;
		ev       = EV_IGNORED;
		if (is_query) begin
			ev = EV_QUERY;
		end else if (is_az) begin
			az_up = !rej_a;
			el_up = b_found_q && !rej_b;
			if (az_up) begin
				az_new = clamp_a;
			end
			if (el_up) begin
				el_new = clamp_b;
			end
			ev = (az_up || el_up) ? EV_TARGET : EV_IGNORED;
		end else if (is_el) begin
			el_up = !rej_a;
			if (el_up) begin
				el_new = clamp_a;
			end
			ev = el_up ? EV_TARGET : EV_IGNORED;
		end else if (is_stop) begin
			ev = EV_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			rd_idx_q    <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			stop_q      <= 1'b0;
			phase_q     <= P_TOK0;
			b_found_q   <= 1'b0;
			for (int j = 0; j < NCAP; j++) begin
				c_q[j] <= 8'h00;
			end
			az_min_q    <= 24'sd0;
			az_max_q    <= 24'sd36000;
			el_min_q    <= 24'sd0;
			el_max_q    <= 24'sd9000;
			az_goal_q   <= '0;
			el_goal_q   <= '0;
			val_a_q     <= '0;
			val_b_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_AZ_MIN: az_min_q <= cfg_data;
					CFG_AZ_MAX: az_max_q <= cfg_data;
					CFG_EL_MIN: el_min_q <= cfg_data;
					CFG_EL_MAX: el_max_q <= cfg_data;
					default: az_min_q <= az_min_q;
				endcase
			end

			if (out_valid_q && out_ready && !cmd.store) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.store) begin
				if (wr_en) begin
					len_q <= len_q + 1'b1;
				end
				out_valid_q <= 1'b1;
				out_user_q  <= EV_STORED;
				out_data_q  <= {6'b0, 1'b0, el_goal_q, 1'b0, az_goal_q};
			end

			if (cmd.line_start) begin
				rd_idx_q  <= '0;
				vld_s1    <= 1'b0;
				stop_q    <= 1'b0;
				phase_q   <= P_TOK0;
				b_found_q <= 1'b0;
				for (int j = 0; j < NCAP; j++) begin
					c_q[j] <= 8'h00;
				end
			end else begin
				vld_s1 <= issue;
				idx_s1 <= rd_idx_q;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (live && (ch == 8'h00)) begin
					stop_q <= 1'b1;
				end
				if (proc) begin
					for (int j = 0; j < NCAP; j++) begin
						if (idx_s1 == LEN_W'(j)) begin
							c_q[j] <= ch;
						end
					end
					case (phase_q)
						P_TOK0: begin
							if (ch == CH_SP) begin
								phase_q <= P_SPACE;
							end
						end
						P_SPACE: begin
							if (ch == CH_UE) begin
								phase_q <= P_E;
							end else if (ch != CH_SP) begin
								phase_q <= P_DONE;
							end
						end
						P_E: begin
							if (ch == CH_UL) begin
								phase_q   <= P_TOK1;
								b_found_q <= 1'b1;
							end else begin
								phase_q <= P_DONE;
							end
						end
						P_TOK1: begin
							if (ch == CH_SP) begin
								phase_q <= P_DONE;
							end
						end
						default: phase_q <= P_DONE;
					endcase
				end
			end

			if (cmd.scale) begin
				val_a_q <= num_a;
				val_b_q <= num_b;
			end

			if (cmd.finish) begin
				len_q       <= '0;
				az_goal_q   <= az_new;
				el_goal_q   <= el_new;
				out_valid_q <= 1'b1;
				out_user_q  <= ev;
				out_data_q  <= {6'b0, el_up, el_new, az_up, az_new};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

>>> hdl/rcl_ctrl.sv
// ----------------------------------------------------------------------------
// rcl_ctrl
// Controller: takes bytes, runs the line scan, scale and finish steps.
// ----------------------------------------------------------------------------
module rcl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rcl_pkg::ctl_sts_t  sts,
	output rcl_pkg::ctl_cmd_t  cmd
);

	import rcl_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SCALE, S_FINISH} state_t;

	state_t state_q;
	logic   take;

	always_comb begin
		in_ready       = (state_q == S_IDLE) && sts.out_free;
		take           = in_ready && in_valid;
		cmd.store      = take && !sts.eol;
		cmd.line_start = take && sts.eol;
		cmd.scan_run   = (state_q == S_SCAN);
		cmd.scale      = (state_q == S_SCALE);
		cmd.finish     = (state_q == S_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take && sts.eol) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE:  state_q <= S_FINISH;
				S_FINISH: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/rotator_command_line_parser.sv
// ----------------------------------------------------------------------------
// rotator_command_line_parser
// Rotator command line parser: buffers bytes, decodes a line at CR or LF.
// ----------------------------------------------------------------------------
// Ordinary byte: stored, and its result item registered as it is accepted.
// Line end: line RAM (one write, one read port) walked a character a cycle;
// scale and finish steps then register the result; a zero byte ends the
// walk early.
// One byte in flight at a time; next byte taken once its result can load.
// Reset clears line length, goals and control, loads default limits; line RAM not cleared.
// ----------------------------------------------------------------------------
module rotator_command_line_parser #(
	parameter int LINE_MAX     = 64,
	parameter int NUMBER_CHARS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // rx_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// az_target[23:0], az_updated[24], el_target[48:25], el_updated[49], zero
	output logic [rcl_pkg::TDATA_W-1:0]         m_axis_tdata,
	output logic [rcl_pkg::EV_W-1:0]            m_axis_tuser,  // event_res
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcl_pkg::GOAL_W-1:0]          cfg_data
);

	import rcl_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	rcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcl_datapath #(
		.LINE_MAX     (LINE_MAX),
		.NUMBER_CHARS (NUMBER_CHARS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotator command line parser. Byte streams of
// command lines, near misses and noise go in through bursty input, replies
// are taken under a stalling receiver and compared per field against a
// line decoder kept in step with every accepted byte and limit write.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcl_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int STORE_DEPTH = 64;
	localparam int NUM_CHARS   = 10;
	localparam int RUN_LIMIT   = 1000000;
	localparam longint DIGIT_CAP = 64'sd1 << 40;

	typedef struct packed {
		rcl_event_t  ev;
		logic [23:0] az;
		logic        az_up;
		logic [23:0] el;
		logic        el_up;
	} parser_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic [EV_W-1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GOAL_W-1:0] cfg_data = '0;

	rotator_command_line_parser #(
		.LINE_MAX(STORE_DEPTH),
		.NUMBER_CHARS(NUM_CHARS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decoder state
	logic [7:0] line_buf [STORE_DEPTH];
	int line_len = 0;
	int text_len = 0;
	logic signed [23:0] az_goal = '0;
	logic signed [23:0] el_goal = '0;
	logic signed [23:0] az_lo = 24'sd0;
	logic signed [23:0] az_hi = 24'sd36000;
	logic signed [23:0] el_lo = 24'sd0;
	logic signed [23:0] el_hi = 24'sd9000;

	logic [7:0] rx_stream [$];
	parser_reply_t parser_replies [$];
	parser_reply_t head_reply;
	int fails = 0;
	int pushed_bytes = 0;
	int rx_taken = 0;
	logic rx_fire = 1'b0;

	function automatic logic [7:0] line_char(input int i);
		return (i < text_len) ? line_buf[i] : 8'h00;
	endfunction

	function automatic int word_end(input int s);
		int p;
		p = s;
		while (p < text_len && line_char(p) != CH_SP)
			p++;
		return p;
	endfunction

	function automatic bit parse_goal(input int s, input int e, input longint lo,
			input longint hi, output logic [23:0] goal);
		int n, p, i, frac;
		longint mag, v;
		bit neg;
		logic [7:0] c;
		n = (e > s) ? e - s : 0;
		if (n > NUM_CHARS)
			n = NUM_CHARS;
		goal = '0;
		for (i = 0; i < n; i++) begin
			c = line_char(s + i);
			if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ))
				return 1'b0;
		end
		p = 0;
		mag = 0;
		neg = 1'b0;
		frac = 0;
		while (p < n && (line_char(s + p) == CH_TAB || line_char(s + p) == CH_VT ||
				line_char(s + p) == CH_FF))
			p++;
		if (p < n && (line_char(s + p) == CH_PLUS || line_char(s + p) == CH_MINUS)) begin
			neg = line_char(s + p) == CH_MINUS;
			p++;
		end
		while (p < n && line_char(s + p) >= CH_0 && line_char(s + p) <= CH_9) begin
			mag = mag * 10 + (longint'(line_char(s + p)) - longint'(CH_0));
			if (mag > DIGIT_CAP)
				mag = DIGIT_CAP;
			p++;
		end
		mag = mag * 100;
		if (p < n && line_char(s + p) == CH_DOT) begin
			p++;
			while (p < n && line_char(s + p) >= CH_0 && line_char(s + p) <= CH_9) begin
				if (frac == 0)
					mag = mag + (longint'(line_char(s + p)) - longint'(CH_0)) * 10;
				else if (frac == 1)
					mag = mag + (longint'(line_char(s + p)) - longint'(CH_0));
				if (frac < 2)
					frac++;
				p++;
			end
		end
		v = neg ? -mag : mag;
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		goal = v[23:0];
		return 1'b1;
	endfunction

	function automatic parser_reply_t parse_rx_byte(input logic [7:0] b);
		parser_reply_t r;
		int i, s, e;
		logic [23:0] g;
		r.ev = EV_STORED;
		r.az_up = 1'b0;
		r.el_up = 1'b0;
		if (b == CH_LF || b == CH_CR) begin
			text_len = line_len;
			for (i = 0; i < line_len && text_len == line_len; i++)
				if (line_buf[i] == 8'h00)
					text_len = i;
			if (line_char(0) == CH_UA && line_char(1) == CH_UZ) begin
				if (line_char(2) == CH_SP && line_char(3) == CH_UE && line_char(4) == CH_UL) begin
					r.ev = EV_QUERY;
				end else begin
					e = word_end(0);
					r.az_up = parse_goal(2, e, longint'(az_lo), longint'(az_hi), g);
					if (r.az_up)
						az_goal = g;
					s = e;
					while (s < text_len && line_char(s) == CH_SP)
						s++;
					if (s < text_len && line_char(s) == CH_UE && line_char(s + 1) == CH_UL) begin
						r.el_up = parse_goal(s + 2, word_end(s), longint'(el_lo),
							longint'(el_hi), g);
						if (r.el_up)
							el_goal = g;
					end
					r.ev = (r.az_up || r.el_up) ? EV_TARGET : EV_IGNORED;
				end
			end else if (line_char(0) == CH_UE && line_char(1) == CH_UL) begin
				r.el_up = parse_goal(2, word_end(0), longint'(el_lo), longint'(el_hi), g);
				if (r.el_up)
					el_goal = g;
				r.ev = r.el_up ? EV_TARGET : EV_IGNORED;
			end else if (line_char(0) == CH_US && line_char(1) == CH_UA &&
					line_char(2) == CH_SP && line_char(3) == CH_US &&
					line_char(4) == CH_UE) begin
				r.ev = EV_STOP;
			end else begin
				r.ev = EV_IGNORED;
			end
			line_len = 0;
		end else if (line_len < STORE_DEPTH) begin
			line_buf[line_len] = b;
			line_len++;
		end
		r.az = az_goal;
		r.el = el_goal;
		return r;
	endfunction

	// accept side: decoder update, limit writes, reply check
	always @(posedge clk) begin
		rx_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				parser_replies.push_back(parse_rx_byte(s_axis_tdata));
				rx_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AZ_MIN: az_lo = cfg_data;
					CFG_AZ_MAX: az_hi = cfg_data;
					CFG_EL_MIN: el_lo = cfg_data;
					CFG_EL_MAX: el_hi = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (parser_replies.size() == 0) begin
					$error("reply item with none outstanding");
					fails++;
				end else begin
					head_reply = parser_replies.pop_front();
					if (m_axis_tuser !== head_reply.ev) begin
						$error("event_res: expected %0d, got %0d", head_reply.ev, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata[23:0] !== head_reply.az) begin
						$error("az_target: expected %0d, got %0d", $signed(head_reply.az),
							$signed(m_axis_tdata[23:0]));
						fails++;
					end
					if (m_axis_tdata[24] !== head_reply.az_up) begin
						$error("az_updated: expected %0d, got %0d", head_reply.az_up,
							m_axis_tdata[24]);
						fails++;
					end
					if (m_axis_tdata[48:25] !== head_reply.el) begin
						$error("el_target: expected %0d, got %0d", $signed(head_reply.el),
							$signed(m_axis_tdata[48:25]));
						fails++;
					end
					if (m_axis_tdata[49] !== head_reply.el_up) begin
						$error("el_updated: expected %0d, got %0d", head_reply.el_up,
							m_axis_tdata[49]);
						fails++;
					end
					if (m_axis_tdata[TDATA_W-1:50] !== '0) begin
						$error("tdata padding: expected 0, got %h", m_axis_tdata[TDATA_W-1:50]);
						fails++;
					end
				end
			end
		end
	end

	// byte sender: bursts and gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		if (s_axis_tvalid && !rx_fire) begin
			// held until taken
		end else if (gap_left > 0) begin
			s_axis_tvalid <= 1'b0;
			gap_left--;
		end else if (rx_stream.size() != 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= rx_stream.pop_front();
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 48);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// reply receiver: stall patterns and long hold-offs
	int hold_left = 0;
	bit hold_done = 1'b0;
	int pattern_kind = 0;
	int pattern_left = 0;
	int pattern_tick = 0;

	always @(negedge clk) begin
		pattern_tick++;
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (!hold_done && rx_taken >= 300) begin
			m_axis_tready <= 1'b0;
			hold_left = 500;
			hold_done = 1'b1;
		end else if ($urandom_range(0, 3999) == 0) begin
			m_axis_tready <= 1'b0;
			hold_left = $urandom_range(100, 400);
		end else begin
			if (pattern_left == 0) begin
				pattern_kind = $urandom_range(0, 3);
				pattern_left = $urandom_range(20, 200);
			end else begin
				pattern_left--;
			end
			case (pattern_kind)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default: m_axis_tready <= (pattern_tick % 4 != 3);
			endcase
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_stream.push_back(b);
		pushed_bytes++;
	endtask

	task automatic push_text(input string t);
		int i;
		for (i = 0; i < t.len(); i++)
			push_byte(t[i]);
	endtask

	task automatic push_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_LF || b == CH_CR)
				b = ~b;
			push_byte(b);
		end
	endtask

	task automatic push_number();
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 2))
				case ($urandom_range(0, 2))
					0: push_byte(CH_TAB);
					1: push_byte(CH_VT);
					default: push_byte(CH_FF);
				endcase
		case ($urandom_range(0, 3))
			0: push_byte(CH_PLUS);
			1: push_byte(CH_MINUS);
			default: ;
		endcase
		repeat (($urandom_range(0, 5) != 0) ? $urandom_range(0, 5) : $urandom_range(6, 14))
			push_byte(CH_0 + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 2) != 0) begin
			push_byte(CH_DOT);
			repeat ($urandom_range(0, 5))
				push_byte(CH_0 + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 11) == 0)
			push_byte(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'($urandom_range(0, 25)));
		else if ($urandom_range(0, 11) == 0)
			push_noise(1);
	endtask

	task automatic push_command_line();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			push_text("AZ");
			push_number();
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(1, 3))
					push_byte(CH_SP);
				push_text("EL");
				push_number();
			end
			if ($urandom_range(0, 7) == 0)
				push_text(" UP");
		end else if (kind < 50) begin
			push_text("EL");
			push_number();
			if ($urandom_range(0, 5) == 0)
				push_text(" AZ1");
		end else if (kind < 58) begin
			push_text("AZ EL");
			if ($urandom_range(0, 3) == 0)
				push_noise($urandom_range(1, 6));
		end else if (kind < 65) begin
			push_text("SA SE");
			if ($urandom_range(0, 3) == 0)
				push_noise($urandom_range(1, 6));
		end else if (kind < 73) begin
			// near misses of the keywords
			repeat ($urandom_range(1, 5))
				case ($urandom_range(0, 7))
					0: push_byte(CH_UA);
					1: push_byte(CH_UZ);
					2: push_byte(CH_UE);
					3: push_byte(CH_UL);
					4: push_byte(CH_US);
					5: push_byte(CH_SP);
					6: push_text("z");
					default: push_text("a");
				endcase
			push_number();
		end else if (kind < 81) begin
			push_noise($urandom_range(0, 20));
		end else if (kind < 85) begin
			// long line that may overrun the line store
			push_text("AZ");
			push_number();
			repeat ($urandom_range(50, 80))
				push_byte($urandom_range(0, 1) ? CH_SP : CH_0 + 8'($urandom_range(0, 9)));
		end else if (kind < 90) begin
			push_text($urandom_range(0, 1) ? "AZ" : "EL");
			push_number();
			push_byte(8'h00);
			push_noise($urandom_range(0, 5));
		end else begin
			push_text("AZ");
			repeat ($urandom_range(1, 2))
				push_byte(CH_SP);
			push_number();
			push_text(" EL");
			push_number();
		end
		case ($urandom_range(0, 9))
			0: push_text("\r\n");
			1, 2, 3, 4: push_byte(CH_CR);
			default: push_byte(CH_LF);
		endcase
	endtask

	task automatic push_random_lines(input int n);
		int start;
		start = pushed_bytes;
		while (pushed_bytes - start < n)
			push_command_line();
	endtask

	task automatic wait_idle();
		while (rx_stream.size() != 0 || s_axis_tvalid || parser_replies.size() != 0)
			@(posedge clk);
		repeat (STORE_DEPTH + 16) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [23:0] azl, input logic [23:0] azh,
			input logic [23:0] ell, input logic [23:0] elh);
		write_limit(CFG_AZ_MIN, azl);
		write_limit(CFG_AZ_MAX, azh);
		write_limit(CFG_EL_MIN, ell);
		write_limit(CFG_EL_MAX, elh);
	endtask

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed lines under reset limits
		push_text("AZ EL\n");
		push_text("AZ1.239 EL-5\r");
		push_text("EL99999999999999\n");
		push_text("SA SE\n");
		push_text("EL\n");
		push_text("\r");
		push_text("AZ12a\n");
		push_text("AZ\t-.5\n");
		push_text("AZ7");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("\n");
		wait_idle();

		set_limits(-24'sd18000, 24'sd18000, -24'sd9000, 24'sd9000);
		push_random_lines(260);
		wait_idle();

		set_limits(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		push_random_lines(260);
		wait_idle();

		// crossed limits: the minimum wins
		set_limits(24'sd5000, -24'sd5000, 24'sd100, -24'sd100);
		push_random_lines(200);
		wait_idle();

		set_limits(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		push_random_lines(250);
		wait_idle();

		set_limits(-24'($urandom_range(0, 40000)), 24'($urandom_range(0, 40000)),
			-24'($urandom_range(0, 20000)), 24'($urandom_range(0, 20000)));
		push_random_lines(250);
		wait_idle();

		set_limits(24'sd0, 24'sd36000, 24'sd0, 24'sd9000);
		push_random_lines(250);
		wait_idle();

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
